@@ sv/assert_macros.svh @@
// assertion macros used by the odometry sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define ODO_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("odometry assertion failed");

// same, on the block clock and reset
`define ODO_ASSERT_CLK(lbl, prop) `ODO_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

@@ sv/odo_pkg.sv @@
// types, constants and helpers for the differential drive odometry block
package odo_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);

  localparam longint PI_Q32    = 64'd13493037705;
  localparam longint PI_F      = (PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
  localparam longint TWO_PI_F  = 2 * PI_F;
  localparam longint HALF_PI_F = PI_F / 2;
  localparam int     RW        = $clog2(TWO_PI_F) + 2;

  // reciprocal of two pi for the heading reduction
  localparam int          MOD_SH    = 50;
  localparam logic [31:0] MOD_RECIP = 32'((64'd1 << MOD_SH) / TWO_PI_F);
  localparam logic [31:0] TWO_PI_W  = 32'(TWO_PI_F);

  localparam int CW = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam int DIV_NW   = 73;
  localparam int DIV_DW   = 48;
  localparam int DIV_QW   = 41;
  localparam int DIV_CNTW = $clog2(DIV_NW + 1);

  localparam logic [DIV_QW-1:0] CAP_TH  = 41'h100_0000_0000;
  localparam logic [DIV_QW-1:0] CAP_MAG = 41'h000_7FFF_FFFF;

  localparam logic [1:0] CFG_MPC = 2'd0;
  localparam logic [1:0] CFG_WB  = 2'd1;
  localparam logic [1:0] CFG_DPR = 2'd2;
  localparam logic [1:0] CFG_SPT = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_DIST, S_SUM, S_DTH, S_DTH_W, S_HEAD, S_MOD, S_MOD_W,
    S_CINIT, S_CORD, S_ADV, S_SPD, S_SPD_W, S_RATE, S_RATE_W, S_OUT
  } odo_state_e;

  typedef enum logic [1:0] {DIV_TH, DIV_SPD, DIV_RATE} odo_div_sel_e;

  typedef struct packed {
    logic         load_in;
    logic         calc_dist;
    logic         calc_sum;
    logic         div_start;
    logic         div_take;
    odo_div_sel_e div_sel;
    logic         head_upd;
    logic         mod_mul;
    logic         mod_fix;
    logic         cord_init;
    logic         cord_step;
    logic         advance;
    logic         load_out;
  } odo_cmd_t;

  typedef struct packed {
    logic div_done;
    logic cord_last;
  } odo_sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
    if (v > 43'sd2147483647) return 32'sh7fffffff;
    else if (v < -43'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] a;
    case (i)
      5'd0:  a = 31'd843314857;
      5'd1:  a = 31'd497837829;
      5'd2:  a = 31'd263043837;
      5'd3:  a = 31'd133525159;
      5'd4:  a = 31'd67021687;
      5'd5:  a = 31'd33543516;
      5'd6:  a = 31'd16775851;
      5'd7:  a = 31'd8388437;
      5'd8:  a = 31'd4194283;
      5'd9:  a = 31'd2097149;
      5'd10: a = 31'd1048576;
      5'd11: a = 31'd524288;
      5'd12: a = 31'd262144;
      5'd13: a = 31'd131072;
      5'd14: a = 31'd65536;
      5'd15: a = 31'd32768;
      5'd16: a = 31'd16384;
      5'd17: a = 31'd8192;
      5'd18: a = 31'd4096;
      5'd19: a = 31'd2048;
      5'd20: a = 31'd1024;
      5'd21: a = 31'd512;
      5'd22: a = 31'd256;
      5'd23: a = 31'd128;
      5'd24: a = 31'd64;
      5'd25: a = 31'd32;
      5'd26: a = 31'd16;
      5'd27: a = 31'd8;
      5'd28: a = 31'd4;
      5'd29: a = 31'd2;
      5'd30: a = 31'd1;
      default: a = 31'd0;
    endcase
    return a;
  endfunction

endpackage

@@ sv/differential_drive_odometry.sv @@
// top level of the differential drive dead-reckoning odometry block
// input channel: in_valid_i/in_ready_o carry one word per update period
//   (right and left hall counts, elapsed timer ticks)
// output channel: out_valid_o/out_ready_i carry one word per input word
//   (x, y, heading in radians and degrees, linear speed, angular rate)
// config: cfg_we_i writes cfg_data_i into register cfg_index_i at once
//   (0 meters per count, 1 wheel base, 2 degrees per radian, 3 tick period)
// one word is taken only after the previous word has finished its update;
//   the 73-step bit-serial divider, run three times per word, and the 16
//   cordic iterations take up most of that update
// a new word is accepted while the previous result still waits; its result
//   is held back until the output register is free, so a stalled receiver
//   delays the block but loses nothing
// reset clears position and heading, loads register defaults and empties
//   the output register
module differential_drive_odometry (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] right_counts_i,
  input  logic signed [15:0] left_counts_i,
  input  logic [15:0]        elapsed_ticks_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] x_pos_o,
  output logic signed [31:0] y_pos_o,
  output logic signed [31:0] heading_rad_o,
  output logic signed [15:0] heading_deg_o,
  output logic signed [31:0] linear_speed_o,
  output logic signed [31:0] angular_rate_o
);
  import odo_pkg::*;

  odo_cmd_t cmd;
  odo_sts_t sts;

  odo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  odo_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .right_counts_i  (right_counts_i),
    .left_counts_i   (left_counts_i),
    .elapsed_ticks_i (elapsed_ticks_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .x_pos_o         (x_pos_o),
    .y_pos_o         (y_pos_o),
    .heading_rad_o   (heading_rad_o),
    .heading_deg_o   (heading_deg_o),
    .linear_speed_o  (linear_speed_o),
    .angular_rate_o  (angular_rate_o)
  );

endmodule

@@ sv/odo_div.sv @@
// bit-serial restoring divider with saturated quotient
module odo_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [odo_pkg::DIV_NW-1:0]    n_i,
  input  logic [odo_pkg::DIV_DW-1:0]    d_i,
  input  logic [odo_pkg::DIV_QW-1:0]    cap_i,
  output logic                          done_o,
  output logic [odo_pkg::DIV_QW-1:0]    q_o
);
  import odo_pkg::*;

  logic                busy_q, busy_d, done_q, done_d;
  logic [DIV_CNTW-1:0] cnt_q, cnt_d;
  logic [DIV_NW-1:0]   num_q;
  logic [DIV_DW-1:0]   rem_q, rem_d, d_q;
  logic [DIV_QW-1:0]   quo_q, cap_q;
  logic                ovf_q;
  logic [DIV_DW:0]     rs, rdiff;
  logic                ge;

  assign rs    = {rem_q, num_q[DIV_NW-1]};
  assign rdiff = rs - {1'b0, d_q};
  assign ge    = rs >= {1'b0, d_q};
  assign rem_d = ge ? rdiff[DIV_DW-1:0] : rs[DIV_DW-1:0];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNTW'(DIV_NW);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= n_i;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
      d_q   <= d_i;
      cap_q <= cap_i;
    end else if (busy_q) begin
      num_q <= {num_q[DIV_NW-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[DIV_QW-2:0], ge};
      ovf_q <= ovf_q | quo_q[DIV_QW-1];
    end
  end

  assign done_o = done_q;
  assign q_o    = (d_q == '0) ? '0 : ((ovf_q || quo_q > cap_q) ? cap_q : quo_q);

endmodule

@@ sv/odo_dp.sv @@
// odometry datapath: scaling, heading, cordic, position and rate registers
module odo_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  input  logic signed [15:0]  right_counts_i,
  input  logic signed [15:0]  left_counts_i,
  input  logic [15:0]         elapsed_ticks_i,
  input  odo_pkg::odo_cmd_t   cmd_i,
  output odo_pkg::odo_sts_t   sts_o,
  output logic signed [31:0]  x_pos_o,
  output logic signed [31:0]  y_pos_o,
  output logic signed [31:0]  heading_rad_o,
  output logic signed [15:0]  heading_deg_o,
  output logic signed [31:0]  linear_speed_o,
  output logic signed [31:0]  angular_rate_o
);
  import odo_pkg::*;

  localparam logic signed [RW-1:0] PI_S   = RW'(PI_F);
  localparam logic signed [RW-1:0] TPI_S  = RW'(TWO_PI_F);
  localparam logic signed [RW-1:0] HPI_S  = RW'(HALF_PI_F);

  logic [23:0] mpc_q, wb_q, dpr_q;
  logic [31:0] spt_q;

  logic signed [15:0] rc_q, lc_q;
  logic [15:0]        ticks_q;
  logic signed [33:0] dr_q, dl_q, sum_q, diff_q;
  logic [47:0]        t_q;
  logic signed [41:0] dtheta_q;
  logic signed [31:0] heading_q, pos_x_q, pos_y_q;
  logic signed [31:0] speed_q, rate_q;
  logic signed [CW-1:0] cx_q, cy_q, cz_q;
  logic               flip_q;
  logic [STEP_W-1:0]  step_q;
  logic [63:0]        mprod_q;
  logic [RW-2:0]      modr_q;

  logic signed [31:0] x_out_q, y_out_q, h_out_q, spd_out_q, rate_out_q;
  logic signed [15:0] deg_out_q, deg_d;

  logic [16:0] rc_mag, lc_mag;
  logic [40:0] prod_r, prod_l;
  logic [31:0] dr_mag, dl_mag, sum_mag, diff_mag, head_mag;
  logic [40:0] dth_mag;

  logic [DIV_NW-1:0] div_n;
  logic [DIV_DW-1:0] div_d;
  logic [DIV_QW-1:0] div_cap, div_q;
  logic              div_done;

  logic signed [42:0] hsum;
  logic [31:0]        mod_qd, mod_r0, mod_r1;
  logic [RW-2:0]      rem;
  logic signed [RW-1:0] rs, r1, r2;
  logic               flip_d;

  logic signed [CW-1:0] xs, ys, at, cos_v, sin_v;
  logic [55:0] dprod;
  logic [23:0] dm;
  logic [14:0] dm_sat;

  function automatic logic signed [31:0] adv(input logic signed [31:0]   p,
                                              input logic signed [33:0]   s,
                                              input logic signed [CW-1:0] tr);
    logic signed [CW-1:0] t22;
    logic [CW-1:0]        tmag;
    logic [22:0]          tm;
    logic [31:0]          smag;
    logic [54:0]          prod;
    logic [31:0]          m;
    logic                 neg;
    t22  = tr >>> 8;
    tmag = tr[CW-1] ? (CW'(0) - t22) : t22;
    tm   = (tmag > CW'(23'h40_0000)) ? 23'h40_0000 : tmag[22:0];
    smag = 32'(s[33] ? -s : s);
    prod = {23'b0, smag} * {32'b0, tm};
    m    = 32'(prod >> 23);
    neg  = s[33] != tr[CW-1];
    if (neg) return sat32($signed({{11{p[31]}}, p}) - $signed({11'b0, m}));
    else return sat32($signed({{11{p[31]}}, p}) + $signed({11'b0, m}));
  endfunction

  assign rc_mag   = rc_q[15] ? (17'd0 - {rc_q[15], rc_q}) : {1'b0, rc_q};
  assign lc_mag   = lc_q[15] ? (17'd0 - {lc_q[15], lc_q}) : {1'b0, lc_q};
  assign prod_r   = {24'b0, rc_mag} * {17'b0, mpc_q};
  assign prod_l   = {24'b0, lc_mag} * {17'b0, mpc_q};
  assign dr_mag   = 32'(prod_r >> (24 - FRAC_BITS));
  assign dl_mag   = 32'(prod_l >> (24 - FRAC_BITS));
  assign sum_mag  = 32'(sum_q[33] ? -sum_q : sum_q);
  assign diff_mag = 32'(diff_q[33] ? -diff_q : diff_q);
  assign dth_mag  = 41'(dtheta_q[41] ? -dtheta_q : dtheta_q);
  assign head_mag = heading_q[31] ? (32'd0 - heading_q) : heading_q;

  always_comb begin
    case (cmd_i.div_sel)
      DIV_TH: begin
        div_n   = DIV_NW'({diff_mag, 16'b0});
        div_d   = DIV_DW'(wb_q);
        div_cap = CAP_TH;
      end
      DIV_SPD: begin
        div_n   = DIV_NW'({sum_mag, 31'b0});
        div_d   = t_q;
        div_cap = CAP_MAG;
      end
      default: begin
        div_n   = DIV_NW'({dth_mag, 32'b0});
        div_d   = t_q;
        div_cap = CAP_MAG;
      end
    endcase
  end

  odo_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .n_i     (div_n),
    .d_i     (div_d),
    .cap_i   (div_cap),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // heading reduction into the cordic range
  assign hsum   = $signed({{11{heading_q[31]}}, heading_q}) + $signed({dtheta_q[41], dtheta_q});
  assign mod_qd = 32'(mprod_q >> MOD_SH) * TWO_PI_W;
  assign mod_r0 = head_mag - mod_qd;
  assign mod_r1 = (mod_r0 >= TWO_PI_W) ? (mod_r0 - TWO_PI_W) : mod_r0;
  assign rem    = modr_q;
  assign rs     = heading_q[31] ? -$signed({1'b0, rem}) : $signed({1'b0, rem});
  always_comb begin
    if (rs > PI_S) r1 = rs - TPI_S;
    else if (rs < -PI_S) r1 = rs + TPI_S;
    else r1 = rs;
    flip_d = 1'b0;
    r2     = r1;
    if (r1 > HPI_S) begin
      r2     = r1 - PI_S;
      flip_d = 1'b1;
    end else if (r1 < -HPI_S) begin
      r2     = r1 + PI_S;
      flip_d = 1'b1;
    end
  end

  assign xs    = cx_q >>> step_q;
  assign ys    = cy_q >>> step_q;
  assign at    = $signed({3'b0, atan_q30(5'(step_q))});
  assign cos_v = flip_q ? -cx_q : cx_q;
  assign sin_v = flip_q ? -cy_q : cy_q;

  assign dprod  = {24'b0, head_mag} * {32'b0, dpr_q};
  assign dm     = 24'(dprod >> (FRAC_BITS + 16));
  assign dm_sat = (dm > 24'd32767) ? 15'h7fff : dm[14:0];
  assign deg_d  = heading_q[31] ? -$signed({1'b0, dm_sat}) : $signed({1'b0, dm_sat});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpc_q     <= 24'd41943;
      wb_q      <= 24'd13107;
      dpr_q     <= 24'd3754936;
      spt_q     <= 32'd298262;
      heading_q <= '0;
      pos_x_q   <= '0;
      pos_y_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_MPC: mpc_q <= cfg_data_i[23:0];
          CFG_WB:  wb_q  <= cfg_data_i[23:0];
          CFG_DPR: dpr_q <= cfg_data_i[23:0];
          CFG_SPT: spt_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.head_upd) heading_q <= sat32(hsum);
      if (cmd_i.advance) begin
        pos_x_q <= adv(pos_x_q, sum_q, cos_v);
        pos_y_q <= adv(pos_y_q, sum_q, sin_v);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      rc_q    <= right_counts_i;
      lc_q    <= left_counts_i;
      ticks_q <= elapsed_ticks_i;
    end
    if (cmd_i.calc_dist) begin
      dr_q <= rc_q[15] ? -$signed({2'b0, dr_mag}) : $signed({2'b0, dr_mag});
      dl_q <= lc_q[15] ? -$signed({2'b0, dl_mag}) : $signed({2'b0, dl_mag});
    end
    if (cmd_i.calc_sum) begin
      sum_q  <= dr_q + dl_q;
      diff_q <= dr_q - dl_q;
      t_q    <= {32'b0, ticks_q} * {16'b0, spt_q};
    end
    if (cmd_i.div_take) begin
      case (cmd_i.div_sel)
        DIV_TH: dtheta_q <= diff_q[33] ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
        DIV_SPD: speed_q <= sum_q[33] ? (32'd0 - div_q[31:0]) : div_q[31:0];
        default: rate_q <= dtheta_q[41] ? (32'd0 - div_q[31:0]) : div_q[31:0];
      endcase
    end
    if (cmd_i.mod_mul) mprod_q <= {32'b0, head_mag} * {32'b0, MOD_RECIP};
    if (cmd_i.mod_fix) modr_q <= mod_r1[RW-2:0];
    if (cmd_i.cord_init) begin
      cx_q   <= CORDIC_GAIN;
      cy_q   <= '0;
      cz_q   <= $signed({{(CW-RW){r2[RW-1]}}, r2}) <<< (30 - FRAC_BITS);
      flip_q <= flip_d;
      step_q <= '0;
    end
    if (cmd_i.cord_step) begin
      step_q <= step_q + 1'b1;
      if (!cz_q[CW-1]) begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - at;
      end else begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + at;
      end
    end
    if (cmd_i.load_out) begin
      x_out_q    <= pos_x_q;
      y_out_q    <= pos_y_q;
      h_out_q    <= heading_q;
      deg_out_q  <= deg_d;
      spd_out_q  <= speed_q;
      rate_out_q <= rate_q;
    end
  end

  assign sts_o.div_done  = div_done;
  assign sts_o.cord_last = step_q == STEP_W'(CORDIC_STEPS - 1);

  assign x_pos_o        = x_out_q;
  assign y_pos_o        = y_out_q;
  assign heading_rad_o  = h_out_q;
  assign heading_deg_o  = deg_out_q;
  assign linear_speed_o = spd_out_q;
  assign angular_rate_o = rate_out_q;

endmodule

@@ sv/odo_ctrl.sv @@
// odometry sequencer: steps the datapath through one update per word
`include "assert_macros.svh"
module odo_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  odo_pkg::odo_sts_t sts_i,
  output odo_pkg::odo_cmd_t cmd_o
);
  import odo_pkg::*;

  odo_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_DIST;
      S_DIST:   state_d = S_SUM;
      S_SUM:    state_d = S_DTH;
      S_DTH:    state_d = S_DTH_W;
      S_DTH_W:  if (sts_i.div_done) state_d = S_HEAD;
      S_HEAD:   state_d = S_MOD;
      S_MOD:    state_d = S_MOD_W;
      S_MOD_W:  state_d = S_CINIT;
      S_CINIT:  state_d = S_CORD;
      S_CORD:   if (sts_i.cord_last) state_d = S_ADV;
      S_ADV:    state_d = S_SPD;
      S_SPD:    state_d = S_SPD_W;
      S_SPD_W:  if (sts_i.div_done) state_d = S_RATE;
      S_RATE:   state_d = S_RATE_W;
      S_RATE_W: if (sts_i.div_done) state_d = S_OUT;
      S_OUT:    if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.div_sel = DIV_TH;
    unique case (state_q)
      S_IDLE:   cmd_o.load_in = in_valid_i;
      S_DIST:   cmd_o.calc_dist = 1'b1;
      S_SUM:    cmd_o.calc_sum = 1'b1;
      S_DTH:    cmd_o.div_start = 1'b1;
      S_DTH_W:  cmd_o.div_take = sts_i.div_done;
      S_HEAD:   cmd_o.head_upd = 1'b1;
      S_MOD:    cmd_o.mod_mul = 1'b1;
      S_MOD_W:  cmd_o.mod_fix = 1'b1;
      S_CINIT:  cmd_o.cord_init = 1'b1;
      S_CORD:   cmd_o.cord_step = 1'b1;
      S_ADV:    cmd_o.advance = 1'b1;
      S_SPD: begin
        cmd_o.div_sel   = DIV_SPD;
        cmd_o.div_start = 1'b1;
      end
      S_SPD_W: begin
        cmd_o.div_sel  = DIV_SPD;
        cmd_o.div_take = sts_i.div_done;
      end
      S_RATE: begin
        cmd_o.div_sel   = DIV_RATE;
        cmd_o.div_start = 1'b1;
      end
      S_RATE_W: begin
        cmd_o.div_sel  = DIV_RATE;
        cmd_o.div_take = sts_i.div_done;
      end
      S_OUT:    cmd_o.load_out = !out_valid_q || out_ready_i;
      default:  ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  `ODO_ASSERT_CLK(a_out_slot, cmd_o.load_out |-> (!out_valid_q || out_ready_i))
  `ODO_ASSERT_CLK(a_accept_dist, (in_valid_i && in_ready_o) |=> (state_q == S_DIST))
  `ODO_ASSERT_CLK(a_div_wait, sts_i.div_done |-> (state_q == S_DTH_W || state_q == S_SPD_W || state_q == S_RATE_W))

endmodule
